// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is checked in reset too.
`define ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/bce_pkg.sv
// ---------------------------------------------------------------------------
// bce_pkg
// Constants, codes and helpers of the biquad cascade equalizer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bce_pkg;

    localparam int MaxSections     = 8;
    localparam int CoefsPerSection = 5;
    localparam int DelayWidth      = 48;
    localparam int DelayFrac       = DelayWidth - 40;
    localparam int SampleWidth     = 32;
    localparam int CoefWidth       = 32;
    localparam int GainWidth       = 17;
    localparam int CountWidth      = 4;
    localparam int SecWidth        = $clog2(MaxSections);
    localparam int CoefAddrWidth   = $clog2(MaxSections * CoefsPerSection);
    localparam int CoefDepth       = MaxSections * CoefsPerSection;
    localparam int DigitWidth      = 4;
    localparam int DigitSteps      = CoefWidth / DigitWidth;
    localparam int ProdWidth       = DelayWidth + CoefWidth + DigitWidth;
    localparam int RoundShift      = 28;
    localparam int GainShift       = 16;
    localparam int InDataWidth     = 72;
    localparam logic [GainWidth-1:0] UnityGain = 17'h10000;

    // Input word kinds.
    typedef enum logic [1:0] {
        FUNC_FILTER = 2'd0,
        FUNC_LOAD   = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    // Coefficient slots within one section.
    typedef enum logic [2:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } t_coef_sel;

    // Configuration register indexes.
    localparam logic CFG_SECTION_COUNT = 1'b0;
    localparam logic CFG_HEADROOM_GAIN = 1'b1;

    // Order of the products within one section: b0, a1, b1, a2, b2.
    function automatic t_coef_sel step_coef(input logic [2:0] step);
        t_coef_sel sel;
        case (step)
            3'd0:    sel = COEF_B0;
            3'd1:    sel = COEF_A1;
            3'd2:    sel = COEF_B1;
            3'd3:    sel = COEF_A2;
            default: sel = COEF_B2;
        endcase
        return sel;
    endfunction

endpackage

`default_nettype wire

// File: rtl/biquad_cascade_equalizer.sv
// ---------------------------------------------------------------------------
// biquad_cascade_equalizer
// Cascade of up to eight transposed direct form II biquads in fixed point,
// with a digit-serial shared multiplier, headroom gain and int32 saturation.
// ---------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tdata: sample_in, coef_section, coef_select, coef_value
//                       tuser: func
//  m_axis    out        tdata: sample_out; tuser: clipped
//  i_cfg     in         write enable, register index, write data
//
//  Input is taken only in the idle state, so a filter word with n sections
//  in use runs to its output before the next accept; each of its 5*n products
//  and the final gain product takes 4 bits of its multiplier per cycle in one
//  shared 48x4 unit. Load, clear and pass-through words take no products.
//  Reset is synchronous and clears control and delay state, not coefficients.
//  A waiting output word does not block input until the next result is ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module biquad_cascade_equalizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [16:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // sample_in[31:0], coef_section[34:32], coef_select[37:35],
    // coef_value[69:38], zero pad[71:70]
    input  logic [71:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // sample_out[31:0]
    output logic [31:0] m_axis_tdata,
    // clipped[0]
    output logic [0:0]  m_axis_tuser
);

    localparam int DW = bce_pkg::DelayWidth;
    localparam int PW = bce_pkg::ProdWidth;
    localparam int CW = bce_pkg::CoefWidth;
    localparam int SW = bce_pkg::SampleWidth;
    localparam int RW = PW - bce_pkg::RoundShift;
    localparam int GW = DW - bce_pkg::DelayFrac + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_ADDR, S_LOAD, S_MUL, S_ACT, S_GAIN, S_OUT
    } t_state;

    // Saturating add at the delay width.
    function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1])
            return s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        return s[DW-1:0];
    endfunction

    // Configuration registers.
    logic [bce_pkg::CountWidth-1:0] r_section_count;
    logic [bce_pkg::GainWidth-1:0]  r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section_count <= '0;
            r_gain          <= bce_pkg::UnityGain;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bce_pkg::CFG_SECTION_COUNT: r_section_count <= i_cfg_wdata[3:0];
                bce_pkg::CFG_HEADROOM_GAIN: r_gain          <= i_cfg_wdata;
                default:                    r_gain          <= r_gain;
            endcase
        end
    end

    // Input field split.
    bce_pkg::t_func                   w_func;
    logic signed [SW-1:0]             w_sample;
    logic [bce_pkg::SecWidth-1:0]     w_csec;
    logic [2:0]                       w_csel;
    logic [CW-1:0]                    w_cval;
    logic                             w_accept;

    assign w_func   = bce_pkg::t_func'(s_axis_tuser);
    assign w_sample = s_axis_tdata[31:0];
    assign w_csec   = s_axis_tdata[34:32];
    assign w_csel   = s_axis_tdata[37:35];
    assign w_cval   = s_axis_tdata[69:38];
    assign w_accept = s_axis_tvalid && s_axis_tready;

    // Sequencer registers.
    t_state                         r_state;
    logic [bce_pkg::SecWidth-1:0]   r_sec;
    logic [bce_pkg::SecWidth-1:0]   r_last;
    logic [2:0]                     r_step;
    logic [2:0]                     r_dig;
    logic signed [DW-1:0]           r_x;
    logic signed [DW-1:0]           r_y;
    logic signed [DW-1:0]           r_acc;
    logic signed [DW-1:0]           r_z1 [bce_pkg::MaxSections];
    logic signed [DW-1:0]           r_z2 [bce_pkg::MaxSections];
    logic [PW-1:0]                  r_prod;
    logic [DW-1:0]                  r_ua;
    logic                           r_neg;
    logic [SW-1:0]                  r_res;
    logic                           r_clip;
    logic                           r_mvalid;
    logic [SW-1:0]                  r_mdata;
    logic                           r_mclip;

    // Coefficient memory, written by load words, with a registered read.
    logic [CW-1:0]                  r_coef_mem [bce_pkg::CoefDepth];
    logic [CW-1:0]                  r_coef_q;
    logic [bce_pkg::CoefAddrWidth-1:0] w_waddr;
    logic [bce_pkg::CoefAddrWidth-1:0] w_raddr;
    logic                           w_cwe;

    assign w_waddr = {1'b0, w_csec, 2'b00} + {3'b000, w_csec} + {3'b000, w_csel};
    assign w_raddr = {1'b0, r_sec, 2'b00} + {3'b000, r_sec}
                   + {3'b000, 3'(bce_pkg::step_coef(r_step))};
    assign w_cwe   = w_accept && (w_func == bce_pkg::FUNC_LOAD)
                   && (w_csel <= 3'(bce_pkg::COEF_A2));

    always_ff @(posedge i_clk) begin
        if (w_cwe)
            r_coef_mem[w_waddr] <= w_cval;
        r_coef_q <= r_coef_mem[w_raddr];
    end

    // Sections in use, capped at the cascade length.
    logic [bce_pkg::CountWidth-1:0] w_n;
    assign w_n = (r_section_count > 4'(bce_pkg::MaxSections))
               ? 4'(bce_pkg::MaxSections) : r_section_count;

    // Coefficient magnitude and multiplicand selection for the next product.
    logic [CW-1:0]        w_uc;
    logic signed [DW-1:0] w_opnd;
    logic [DW-1:0]        w_uopnd;
    logic                 w_ynode;
    assign w_uc    = r_coef_q[CW-1] ? (~r_coef_q + 1'b1) : r_coef_q;
    assign w_ynode = (r_step == 3'd1) || (r_step == 3'd3);
    assign w_opnd  = w_ynode ? r_y : r_x;
    assign w_uopnd = w_opnd[DW-1] ? (~w_opnd + 1'b1) : w_opnd;

    // One digit step: add multiplicand times the low digit, shift right.
    logic [DW+bce_pkg::DigitWidth-1:0] w_pp;
    logic [PW-DW-CW+DW:0] w_mac;
    assign w_pp  = r_ua * r_prod[bce_pkg::DigitWidth-1:0];
    assign w_mac = {1'b0, r_prod[PW-1:CW]} + {1'b0, w_pp};

    // Round half away from zero at 2^-28, then saturate with sign.
    logic [RW-1:0]        w_round;
    logic signed [DW-1:0] w_m;
    assign w_round = r_prod[PW-1:bce_pkg::RoundShift]
                   + RW'(r_prod[bce_pkg::RoundShift-1]);
    always_comb begin
        if (w_round >= RW'({1'b1, {(DW-1){1'b0}}}))
            w_m = r_neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        else if (r_neg)
            w_m = -$signed(w_round[DW-1:0]);
        else
            w_m = w_round[DW-1:0];
    end

    // Gain result: product shifted right by 16, magnitude 41 bits.
    logic [GW-1:0] w_gmag;
    assign w_gmag = r_prod[bce_pkg::GainShift+GW-1:bce_pkg::GainShift];

    // Effective gain, zero or above unity taken as unity.
    logic [bce_pkg::GainWidth-1:0] w_geff;
    assign w_geff = ((r_gain == '0) || (r_gain > bce_pkg::UnityGain))
                  ? bce_pkg::UnityGain : r_gain;

    // Magnitude of the cascade output; its integer part feeds the gain product.
    logic [DW-1:0] w_xmag;
    assign w_xmag = r_x[DW-1] ? (~r_x + 1'b1) : r_x;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tuser  = r_mclip;

    // Sequencer, delay state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mvalid <= 1'b0;
            for (int i = 0; i < bce_pkg::MaxSections; i++) begin
                r_z1[i] <= '0;
                r_z2[i] <= '0;
            end
        end else begin
            if (r_mvalid && m_axis_tready && (r_state != S_OUT))
                r_mvalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (w_func)
                            bce_pkg::FUNC_FILTER: begin
                                r_sec  <= '0;
                                r_step <= '0;
                                r_last <= 3'(w_n - 1'b1);
                                r_x    <= {{(DW-SW-bce_pkg::DelayFrac){w_sample[SW-1]}},
                                           w_sample, {bce_pkg::DelayFrac{1'b0}}};
                                if (w_n == '0) begin
                                    r_res   <= w_sample;
                                    r_clip  <= 1'b0;
                                    r_state <= S_OUT;
                                end else begin
                                    r_state <= S_ADDR;
                                end
                            end
                            bce_pkg::FUNC_CLEAR: begin
                                for (int i = 0; i < bce_pkg::MaxSections; i++) begin
                                    r_z1[i] <= '0;
                                    r_z2[i] <= '0;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_ADDR: r_state <= S_LOAD;
                S_LOAD: begin
                    r_ua    <= w_uopnd;
                    r_neg   <= w_opnd[DW-1] ^ r_coef_q[CW-1] ^ w_ynode;
                    r_prod  <= {{(PW-CW){1'b0}}, w_uc};
                    r_dig   <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod <= {3'b000, w_mac, r_prod[CW-1:bce_pkg::DigitWidth]};
                    r_dig  <= r_dig + 1'b1;
                    if (r_dig == 3'(bce_pkg::DigitSteps - 1))
                        r_state <= S_ACT;
                end
                S_ACT: begin
                    case (r_step)
                        3'd0: r_y   <= sat_add(w_m, r_z1[r_sec]);
                        3'd1: r_acc <= w_m;
                        3'd2: r_z1[r_sec] <= sat_add(sat_add(r_acc, w_m), r_z2[r_sec]);
                        3'd3: r_acc <= w_m;
                        3'd4: begin
                            r_z2[r_sec] <= sat_add(w_m, r_acc);
                            r_x         <= r_y;
                        end
                        default: begin
                            if (r_neg) begin
                                r_clip <= (w_gmag > GW'(32'h80000000));
                                r_res  <= (w_gmag > GW'(32'h80000000)) ? 32'h80000000
                                        : 32'(-w_gmag);
                            end else begin
                                r_clip <= (w_gmag > GW'(32'h7FFFFFFF));
                                r_res  <= (w_gmag > GW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF
                                        : w_gmag[SW-1:0];
                            end
                        end
                    endcase
                    if (r_step == 3'd4) begin
                        if (r_sec == r_last) begin
                            r_step  <= 3'd5;
                            r_state <= S_GAIN;
                        end else begin
                            r_sec   <= r_sec + 1'b1;
                            r_step  <= '0;
                            r_state <= S_ADDR;
                        end
                    end else if (r_step == 3'd5) begin
                        r_state <= S_OUT;
                    end else begin
                        r_step  <= r_step + 1'b1;
                        r_state <= S_ADDR;
                    end
                end
                S_GAIN: begin
                    r_ua    <= {{bce_pkg::DelayFrac{1'b0}},
                                w_xmag[DW-1:bce_pkg::DelayFrac]};
                    r_neg   <= r_x[DW-1];
                    r_prod  <= {{(PW-bce_pkg::GainWidth){1'b0}}, w_geff};
                    r_dig   <= '0;
                    r_state <= S_MUL;
                end
                S_OUT: begin
                    if (!r_mvalid || m_axis_tready) begin
                        r_mvalid <= 1'b1;
                        r_mdata  <= r_res;
                        r_mclip  <= r_clip;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/bce_checker.sv
// ---------------------------------------------------------------------------
// bce_checker
// Port-level checks of the biquad cascade equalizer, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bce_port_checks (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [bce_pkg::SampleWidth-1:0] m_axis_tdata,
    input wire logic [0:0]                      m_axis_tuser
);

    // A clipped word carries one of the two int32 limits.
    `ASSERT_IMP(a_clip_limit, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata == 32'h7FFFFFFF) || (m_axis_tdata == 32'h80000000))

    // No output word is offered right after reset.
    `ASSERT_NXT_ALWAYS(a_rst_idle, i_clk, !i_rst_n, !m_axis_tvalid)

    // A stalled output word holds.
    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind biquad_cascade_equalizer bce_port_checks u_bce_port_checks (.*);

`default_nettype wire
